### rtl/tcce_pkg.sv
// ----------------------------------------------------------------------------
// Text console cursor engine: shared definitions
// Item types, command and state codes, character codes and defaults used by
// every module of the console engine.
// ----------------------------------------------------------------------------
package tcce_pkg;

  // Default screen geometry.
  localparam int DEF_ROWS = 25;
  localparam int DEF_COLS = 80;

  // Widths of the target fields and of the reported offset.
  localparam int TROW_W = 6;
  localparam int TCOL_W = 7;
  localparam int OFF_W  = 11;
  // Wide enough for any cell count or offset at the largest geometry.
  localparam int XOFF_W = 14;

  // Character codes.
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_BLANK  = 8'h20;
  localparam logic [7:0] CH_PR_LO  = 8'h20;
  localparam logic [7:0] CH_PR_HI  = 8'h7E;
  localparam logic [7:0] RESET_ATTR = 8'd15;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLOR  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CURSOR_HIDE = 4'd1;

  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_SET   = 2'd1,
    CMD_READ  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADDR,
    S_EXEC,
    S_SWEEP,
    S_OFF,
    S_DONE
  } state_t;

  // One screen cell: attribute in the upper byte, character in the lower.
  typedef struct packed {
    logic [7:0] attr;
    logic [7:0] ch;
  } cell_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [7:0]        byte_in;
    logic [TROW_W-1:0] target_row;
    logic [TCOL_W-1:0] target_col;
  } req_t;

  typedef struct packed {
    logic [4:0]       cursor_row_out;
    logic [6:0]       cursor_col_out;
    logic [OFF_W-1:0] hw_cursor_offset;
    logic             scrolled;
    logic             status;
    logic [7:0]       read_char;
    logic [7:0]       read_attr;
  } rsp_t;

endpackage

### rtl/text_console_cursor_engine.sv
// ----------------------------------------------------------------------------
// Text console cursor engine
// Screen store of character and attribute cells with a cursor: put byte,
// set cursor, read cell and clear screen, one result item per command item.
//
//   Channel  Handshake                  Payload
//   req      req_valid / req_stall      req_t: cmd, byte_in, target_row/col
//   rsp      rsp_valid / rsp_stall      rsp_t: cursor, offset, flags, cell
//   cfg      cfg_valid / cfg_ready      cfg_index, cfg_data
//
// Accepted only when idle, an item runs the address, execute, offset and done
// states in that order, and its result item is registered from done; a new
// item is taken only after the last returns to idle. A scroll or a clear adds
// a sweep of the store, one cell per cycle on the single store write port.
// Reset starts the same sweep to blank the store, with req_stall high; cfg
// writes are taken at any time. A stalled result holds the next item in done.
// ----------------------------------------------------------------------------
module text_console_cursor_engine import tcce_pkg::*; #(
  parameter int ROWS = DEF_ROWS,
  parameter int COLS = DEF_COLS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  req_t                 req,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output rsp_t                 rsp,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  localparam int AW = $clog2(ROWS * COLS);

  logic [7:0]        text_color;
  logic              cursor_hide;
  logic              busy;
  logic              slot_free;
  logic              done;
  rsp_t              result;
  logic [TROW_W-1:0] unit_row;
  logic [TCOL_W-1:0] unit_col;
  logic [AW-1:0]     unit_addr;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  cell_t             mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  cell_t             mem_rdata;

  assign req_stall = busy;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      text_color  <= RESET_ATTR;
      cursor_hide <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TEXT_COLOR:  text_color  <= cfg_data;
        REG_CURSOR_HIDE: cursor_hide <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Response register.
  assign slot_free = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (done) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      rsp <= result;
    end
  end

  tcce_ctrl #(.ROWS(ROWS), .COLS(COLS)) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req         (req),
    .busy        (busy),
    .text_color  (text_color),
    .cursor_hide (cursor_hide),
    .slot_free   (slot_free),
    .done        (done),
    .result      (result),
    .unit_row    (unit_row),
    .unit_col    (unit_col),
    .unit_addr   (unit_addr),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_re      (mem_re),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata)
  );

  tcce_addr_unit #(.ROWS(ROWS), .COLS(COLS)) u_addr (
    .clk  (clk),
    .row  (unit_row),
    .col  (unit_col),
    .addr (unit_addr)
  );

  tcce_store #(.ROWS(ROWS), .COLS(COLS)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

### rtl/tcce_store.sv
// ----------------------------------------------------------------------------
// Screen store
// One cell per screen position, one write port and one read port with a
// registered read.
// ----------------------------------------------------------------------------
module tcce_store import tcce_pkg::*; #(
  parameter int ROWS = DEF_ROWS,
  parameter int COLS = DEF_COLS
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(ROWS*COLS)-1:0]     waddr,
  input  cell_t                            wdata,
  input  logic                             re,
  input  logic [$clog2(ROWS*COLS)-1:0]     raddr,
  output cell_t                            rdata
);

  localparam int CELLS = ROWS * COLS;

  cell_t mem [CELLS];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/tcce_addr_unit.sv
// ----------------------------------------------------------------------------
// Cell address unit
// Shared registered multiply-add that turns a row and column into a linear
// cell address; used for the cursor, the target and the reported offset.
// ----------------------------------------------------------------------------
module tcce_addr_unit import tcce_pkg::*; #(
  parameter int ROWS = DEF_ROWS,
  parameter int COLS = DEF_COLS
) (
  input  logic                         clk,
  input  logic [TROW_W-1:0]            row,
  input  logic [TCOL_W-1:0]            col,
  output logic [$clog2(ROWS*COLS)-1:0] addr
);

  localparam int AW = $clog2(ROWS * COLS);

  // Result is only meaningful for on-screen operands.
  always_ff @(posedge clk) begin
    addr <= AW'(row * COLS + col);
  end

endmodule

### rtl/tcce_ctrl.sv
// ----------------------------------------------------------------------------
// Console sequencer
// Holds the cursor, decodes each command and steps the address unit and the
// screen store through the cell write, the cell read and the store sweeps.
// ----------------------------------------------------------------------------
module tcce_ctrl import tcce_pkg::*; #(
  parameter int ROWS = DEF_ROWS,
  parameter int COLS = DEF_COLS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  input  req_t                         req,
  output logic                         busy,
  input  logic [7:0]                   text_color,
  input  logic                         cursor_hide,
  input  logic                         slot_free,
  output logic                         done,
  output rsp_t                         result,
  output logic [TROW_W-1:0]            unit_row,
  output logic [TCOL_W-1:0]            unit_col,
  input  logic [$clog2(ROWS*COLS)-1:0] unit_addr,
  output logic                         mem_we,
  output logic [$clog2(ROWS*COLS)-1:0] mem_waddr,
  output cell_t                        mem_wdata,
  output logic                         mem_re,
  output logic [$clog2(ROWS*COLS)-1:0] mem_raddr,
  input  cell_t                        mem_rdata
);

  localparam int CELLS = ROWS * COLS;
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLS);
  localparam int AW    = $clog2(CELLS);
  localparam int SW    = $clog2(CELLS + 1);
  localparam logic [XOFF_W-1:0] CELLS_X = XOFF_W'(CELLS);

  state_t         state, state_next;
  req_t           item;
  logic [RW-1:0]  cur_row;
  logic [CW-1:0]  cur_col;
  logic           rolled;
  logic           status;
  logic [7:0]     rd_char;
  logic [7:0]     rd_attr;
  logic [SW-1:0]  sweep_cnt;
  logic           sweep_copy;
  logic           sweep_cmd;
  logic [7:0]     sweep_attr;

  logic           is_print;
  logic           tgt_ok;
  logic           row_last;
  logic           col_last;
  logic           need_scroll;
  logic           sweep_end;
  logic [SW-1:0]  sweep_prev;
  logic [SW:0]    sweep_src;
  logic [XOFF_W-1:0] addr_x;

  // Decodes of the held item and the cursor.
  assign is_print  = (item.byte_in >= CH_PR_LO) && (item.byte_in <= CH_PR_HI);
  assign tgt_ok    = ({1'b0, item.target_row} < 7'(ROWS)) &&
                     ({1'b0, item.target_col} < 8'(COLS));
  assign row_last  = cur_row == RW'(ROWS - 1);
  assign col_last  = cur_col == CW'(COLS - 1);
  assign need_scroll = row_last &&
                       ((item.byte_in == CH_NL) || (is_print && col_last));

  // Sweep addressing: read one row ahead, write one cell behind in the cycle after.
  assign sweep_end  = sweep_cnt == SW'(CELLS);
  assign sweep_prev = sweep_cnt - SW'(1);
  assign sweep_src  = (SW + 1)'(sweep_cnt) + (SW + 1)'(COLS);

  // Next state, store and address unit control.
  always_comb begin
    state_next = state;
    busy       = 1'b1;
    done       = 1'b0;
    unit_row   = TROW_W'(cur_row);
    unit_col   = TCOL_W'(cur_col);
    mem_we     = 1'b0;
    mem_waddr  = unit_addr;
    mem_wdata  = '{attr: text_color, ch: CH_BLANK};
    mem_re     = 1'b0;
    mem_raddr  = unit_addr;
    unique case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (req_valid) begin
          state_next = S_ADDR;
        end
      end
      S_ADDR: begin
        if (item.cmd != CMD_PUT) begin
          unit_row = item.target_row;
          unit_col = item.target_col;
        end
        state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_OFF;
        case (item.cmd)
          CMD_PUT: begin
            if (item.byte_in == CH_BS) begin
              if ((cur_col != '0) || (cur_row != '0)) begin
                mem_we    = 1'b1;
                mem_waddr = unit_addr - AW'(1);
              end
            end else if (is_print) begin
              mem_we    = 1'b1;
              mem_wdata = '{attr: text_color, ch: item.byte_in};
            end
            if (need_scroll) begin
              state_next = S_SWEEP;
            end
          end
          CMD_READ: begin
            mem_re = tgt_ok;
          end
          CMD_CLEAR: begin
            state_next = S_SWEEP;
          end
          default: begin
          end
        endcase
      end
      S_SWEEP: begin
        mem_re    = sweep_copy && (sweep_src < (SW + 1)'(CELLS));
        mem_raddr = sweep_src[AW-1:0];
        mem_we    = sweep_cnt != '0;
        mem_waddr = sweep_prev[AW-1:0];
        if (sweep_copy && (sweep_prev < SW'(CELLS - COLS))) begin
          mem_wdata = mem_rdata;
        end else begin
          mem_wdata = '{attr: sweep_attr, ch: CH_BLANK};
        end
        if (sweep_end) begin
          state_next = sweep_cmd ? S_OFF : S_IDLE;
        end
      end
      S_OFF: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        done = slot_free;
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register; reset starts the blanking sweep of the store.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  // Cursor, sweep control and per-item result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_row    <= '0;
      cur_col    <= '0;
      sweep_cnt  <= '0;
      sweep_copy <= 1'b0;
      sweep_cmd  <= 1'b0;
      sweep_attr <= RESET_ATTR;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            item    <= req;
            rolled  <= 1'b0;
            status  <= 1'b0;
            rd_char <= '0;
            rd_attr <= '0;
          end
        end
        S_EXEC: begin
          sweep_cnt  <= '0;
          sweep_cmd  <= 1'b1;
          sweep_attr <= text_color;
          case (item.cmd)
            CMD_PUT: begin
              sweep_copy <= 1'b1;
              if (item.byte_in == CH_CR) begin
                cur_col <= '0;
              end else if (item.byte_in == CH_BS) begin
                if (cur_col != '0) begin
                  cur_col <= cur_col - CW'(1);
                end else if (cur_row != '0) begin
                  cur_row <= cur_row - RW'(1);
                  cur_col <= CW'(COLS - 1);
                end
              end else if ((item.byte_in == CH_NL) || (is_print && col_last)) begin
                // Next line; on the last row the scroll keeps the row.
                cur_col <= '0;
                if (row_last) begin
                  rolled <= 1'b1;
                end else begin
                  cur_row <= cur_row + RW'(1);
                end
              end else if (is_print) begin
                cur_col <= cur_col + CW'(1);
              end else begin
                status <= 1'b1;
              end
            end
            CMD_SET: begin
              if (tgt_ok) begin
                cur_row <= RW'(item.target_row);
                cur_col <= CW'(item.target_col);
              end else begin
                status <= 1'b1;
              end
            end
            CMD_READ: begin
              status <= !tgt_ok;
            end
            CMD_CLEAR: begin
              sweep_copy <= 1'b0;
              cur_row    <= '0;
              cur_col    <= '0;
            end
            default: begin
            end
          endcase
        end
        S_SWEEP: begin
          sweep_cnt <= sweep_cnt + SW'(1);
        end
        S_OFF: begin
          // Read data from the store arrives in this cycle.
          if ((item.cmd == CMD_READ) && !status) begin
            rd_char <= mem_rdata.ch;
            rd_attr <= mem_rdata.attr;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Result item, valid while in the final state.
  assign addr_x = XOFF_W'(unit_addr);

  always_comb begin
    result.cursor_row_out   = 5'(cur_row);
    result.cursor_col_out   = 7'(cur_col);
    result.hw_cursor_offset = cursor_hide ? CELLS_X[OFF_W-1:0] : addr_x[OFF_W-1:0];
    result.scrolled         = rolled;
    result.status           = status;
    result.read_char        = rd_char;
    result.read_attr        = rd_attr;
  end

endmodule

### test/tb_top.sv
// ----------------------------------------------------------------------------
// Testbench for the text console cursor engine
// Drives command items through the request channel with bursty timing,
// stalls the result channel on a pattern of its own, and checks every result
// item field by field against a predictor of the screen store and cursor.
// A short directed run covers the byte classes, control codes, wrapping,
// scrolling, off-screen targets and clearing. It is followed by random
// phases under several colour and cursor-hide settings.
// ----------------------------------------------------------------------------
module tb_top;
  import tcce_pkg::*;

  localparam int SCR_ROWS     = DEF_ROWS;
  localparam int SCR_COLS     = DEF_COLS;
  localparam int SCR_CELLS    = SCR_ROWS * SCR_COLS;
  // Room for a full sweep of the store plus the pipeline.
  localparam int SWEEP_CYCLES = SCR_CELLS + 16;
  localparam int NUM_PHASES   = 5;
  localparam int PHASE_ITEMS  = 335;
  localparam int MAX_REPORTS  = 30;

  typedef enum int {STALL_NONE, STALL_SCATTER, STALL_LONG} stall_mode_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 req_valid = 1'b0;
  logic                 req_stall;
  req_t                 req = '0;
  logic                 rsp_valid;
  logic                 rsp_stall = 1'b0;
  rsp_t                 rsp;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data = '0;

  // Predicted screen store, cursor and register settings.
  cell_t       screen_img [SCR_CELLS];
  int          csr_row;
  int          csr_col;
  logic [7:0]  text_attr;
  logic        hide_pred;

  req_t        pending_cmds [$];
  rsp_t        expected_rsp [$];
  rsp_t        want_rsp;

  int          mismatches = 0;
  int          results_checked = 0;
  int          cmds_queued = 0;
  int          scroll_count = 0;
  int          clear_count = 0;
  int          reject_count = 0;

  int          burst_left = 8;
  int          gap_left = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int          mode_left = 0;
  int          stall_hold = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  text_console_cursor_engine #(
    .ROWS(SCR_ROWS),
    .COLS(SCR_COLS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Move the predicted cursor to the start of the next row, scrolling the
  // store up one row first when the cursor sits on the last row.
  function automatic bit advance_line();
    bit rolled = 1'b0;
    if (csr_row + 1 >= SCR_ROWS) begin
      for (int i = 0; i < (SCR_ROWS - 1) * SCR_COLS; i++)
        screen_img[i] = screen_img[i + SCR_COLS];
      for (int i = (SCR_ROWS - 1) * SCR_COLS; i < SCR_CELLS; i++)
        screen_img[i] = {text_attr, CH_BLANK};
      if (csr_row > 0)
        csr_row--;
      rolled = 1'b1;
      scroll_count++;
    end
    csr_row++;
    csr_col = 0;
    return rolled;
  endfunction

  // Apply one command item to the predicted state and return its result item.
  function automatic rsp_t predict_console(input req_t r);
    rsp_t e;
    int   idx;
    bit   on_screen;
    e = '0;
    on_screen = (r.target_row < SCR_ROWS) && (r.target_col < SCR_COLS);
    idx = r.target_row * SCR_COLS + r.target_col;
    case (r.cmd)
      CMD_PUT: begin
        if (r.byte_in == CH_NL) begin
          e.scrolled = advance_line();
        end else if (r.byte_in == CH_CR) begin
          csr_col = 0;
        end else if (r.byte_in == CH_BS) begin
          if (csr_col != 0) begin
            csr_col--;
            screen_img[csr_row * SCR_COLS + csr_col] = {text_attr, CH_BLANK};
          end else if (csr_row != 0) begin
            csr_row--;
            csr_col = SCR_COLS - 1;
            screen_img[csr_row * SCR_COLS + csr_col] = {text_attr, CH_BLANK};
          end
        end else if (r.byte_in >= CH_PR_LO && r.byte_in <= CH_PR_HI) begin
          screen_img[csr_row * SCR_COLS + csr_col] = {text_attr, r.byte_in};
          if (csr_col + 1 >= SCR_COLS)
            e.scrolled = advance_line();
          else
            csr_col++;
        end else begin
          e.status = 1'b1;
        end
      end
      CMD_SET: begin
        if (on_screen) begin
          csr_row = int'(r.target_row);
          csr_col = int'(r.target_col);
        end else begin
          e.status = 1'b1;
        end
      end
      CMD_READ: begin
        if (on_screen) begin
          e.read_char = screen_img[idx].ch;
          e.read_attr = screen_img[idx].attr;
        end else begin
          e.status = 1'b1;
        end
      end
      default: begin
        for (int i = 0; i < SCR_CELLS; i++)
          screen_img[i] = {text_attr, CH_BLANK};
        csr_row = 0;
        csr_col = 0;
        clear_count++;
      end
    endcase
    if (e.status)
      reject_count++;
    e.cursor_row_out   = 5'(csr_row);
    e.cursor_col_out   = 7'(csr_col);
    e.hw_cursor_offset = OFF_W'(hide_pred ? SCR_CELLS : csr_row * SCR_COLS + csr_col);
    return e;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("MISMATCH at result %0d: %s got %0d, expected %0d",
               results_checked, what, got, want);
  endtask

  task automatic push_command(input cmd_t op, input logic [7:0] chr,
                              input int row, input int col);
    req_t r;
    r.cmd        = op;
    r.byte_in    = chr;
    r.target_row = TROW_W'(row);
    r.target_col = TCOL_W'(col);
    pending_cmds.push_back(r);
    cmds_queued++;
  endtask

  // Random byte of any value, and random printable byte.
  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] rand_print();
    return 8'($urandom_range(CH_PR_LO, CH_PR_HI));
  endfunction

  // A put item carries random content in its unused target fields.
  task automatic put_byte(input logic [7:0] chr);
    push_command(CMD_PUT, chr, $urandom_range(0, 63), $urandom_range(0, 127));
  endtask

  // Wait until no item is pending or in flight, then let any sweep finish.
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || req_valid || expected_rsp.size() != 0);
    repeat (SWEEP_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_TEXT_COLOR)
      text_attr = val;
    else if (idx == REG_CURSOR_HIDE)
      hide_pred = val[0];
  endtask

  // Queue one phase of random sequences: mostly text runs, wraps, scrolls and
  // read-backs, with some backspacing, noise and the odd clear.
  task automatic queue_random_phase(input int n_items);
    int stop_at;
    int pick;
    int roll;
    int r0;
    int c0;
    int k;
    stop_at = cmds_queued + n_items;
    while (cmds_queued < stop_at) begin
      pick = $urandom_range(0, 99);
      r0   = $urandom_range(0, SCR_ROWS - 1);
      c0   = $urandom_range(0, SCR_COLS - 1);
      if (pick < 35) begin
        push_command(CMD_SET, rand_byte(), r0, c0);
        repeat ($urandom_range(3, 30)) begin
          roll = $urandom_range(0, 19);
          if (roll == 0)
            put_byte(CH_CR);
          else if (roll == 1)
            put_byte(CH_BS);
          else if (roll == 2)
            put_byte(CH_NL);
          else
            put_byte(rand_print());
        end
        repeat ($urandom_range(1, 4))
          push_command(CMD_READ, rand_byte(), r0,
                       $urandom_range(0, SCR_COLS - 1));
      end else if (pick < 50) begin
        // Printing across the line end, on the last row half of the time.
        k = $urandom_range(0, 3);
        if ($urandom_range(0, 1) == 1)
          r0 = SCR_ROWS - 1;
        push_command(CMD_SET, rand_byte(), r0, SCR_COLS - 1 - k);
        repeat (k + 1 + $urandom_range(0, 2))
          put_byte(rand_print());
        push_command(CMD_READ, rand_byte(), r0, SCR_COLS - 1);
      end else if (pick < 60) begin
        push_command(CMD_SET, rand_byte(), SCR_ROWS - 1, c0);
        put_byte(CH_NL);
        push_command(CMD_READ, rand_byte(), SCR_ROWS - 2, c0);
      end else if (pick < 70) begin
        if ($urandom_range(0, 9) < 3)
          r0 = 0;
        if ($urandom_range(0, 1) == 1)
          c0 = 0;
        push_command(CMD_SET, rand_byte(), r0, c0);
        repeat ($urandom_range(1, 4))
          put_byte(CH_BS);
        push_command(CMD_READ, rand_byte(), r0, c0);
      end else if (pick < 80) begin
        repeat ($urandom_range(1, 6))
          push_command(CMD_READ, rand_byte(),
                       $urandom_range(0, SCR_ROWS - 1), $urandom_range(0, SCR_COLS - 1));
      end else if (pick < 97) begin
        // Noise: any field value, off-screen targets and unprintable bytes.
        repeat ($urandom_range(1, 5))
          push_command(($urandom_range(0, 39) == 0) ? CMD_CLEAR
                                                    : cmd_t'($urandom_range(0, 2)),
                       rand_byte(), $urandom_range(0, 63),
                       $urandom_range(0, 127));
      end else begin
        push_command(CMD_CLEAR, rand_byte(), $urandom_range(0, 63),
                     $urandom_range(0, 127));
        push_command(CMD_READ, rand_byte(), r0, c0);
        put_byte(rand_print());
      end
    end
  endtask

  // Request driver: predicts each accepted item and presents the next one in
  // bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall)
        expected_rsp.push_back(predict_console(req));
      if (!req_valid || !req_stall) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          req_valid <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          req <= pending_cmds.pop_front();
          req_valid <= 1'b1;
          burst_left = burst_left - 1;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Result stall pattern: free-running, scattered stalls, or long stalls, with the
  // mode picked again at random whenever its countdown runs out.
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(50, 400);
      end else begin
        mode_left = mode_left - 1;
      end
      if (stall_hold > 0) begin
        stall_hold = stall_hold - 1;
        rsp_stall <= 1'b1;
      end else begin
        case (stall_mode)
          STALL_NONE: rsp_stall <= 1'b0;
          STALL_SCATTER: rsp_stall <= ($urandom_range(0, 2) == 0);
          default: begin
            if ($urandom_range(0, 9) == 0) begin
              stall_hold = $urandom_range(1, 20);
              rsp_stall <= 1'b1;
            end else begin
              rsp_stall <= 1'b0;
            end
          end
        endcase
      end
    end
  end

  // Result monitor: each accepted item is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_rsp.size() == 0) begin
        report_mismatch("unexpected result item, offset", rsp.hw_cursor_offset, 0);
      end else begin
        want_rsp = expected_rsp.pop_front();
        if (rsp.cursor_row_out !== want_rsp.cursor_row_out)
          report_mismatch("cursor_row_out", rsp.cursor_row_out, want_rsp.cursor_row_out);
        if (rsp.cursor_col_out !== want_rsp.cursor_col_out)
          report_mismatch("cursor_col_out", rsp.cursor_col_out, want_rsp.cursor_col_out);
        if (rsp.hw_cursor_offset !== want_rsp.hw_cursor_offset)
          report_mismatch("hw_cursor_offset", rsp.hw_cursor_offset,
                          want_rsp.hw_cursor_offset);
        if (rsp.scrolled !== want_rsp.scrolled)
          report_mismatch("scrolled", rsp.scrolled, want_rsp.scrolled);
        if (rsp.status !== want_rsp.status)
          report_mismatch("status", rsp.status, want_rsp.status);
        if (rsp.read_char !== want_rsp.read_char)
          report_mismatch("read_char", rsp.read_char, want_rsp.read_char);
        if (rsp.read_attr !== want_rsp.read_attr)
          report_mismatch("read_attr", rsp.read_attr, want_rsp.read_attr);
      end
      results_checked++;
    end
  end

  // Stimulus sequence: reset, directed items, then random phases.
  initial begin
    logic [7:0] phase_colour [NUM_PHASES];
    logic       phase_hide [NUM_PHASES];
    phase_colour = '{8'h00, 8'hFF, 8'($urandom_range(1, 254)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))};
    phase_hide   = '{1'b1, 1'b0, 1'b1, 1'b0, 1'($urandom_range(0, 1))};

    text_attr     = RESET_ATTR;
    hide_pred     = 1'b0;
    csr_row       = 0;
    csr_col       = 0;
    for (int i = 0; i < SCR_CELLS; i++)
      screen_img[i] = {RESET_ATTR, CH_BLANK};

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset contents, byte classes, wrapping, scrolling, off-screen
    // targets and a clear, all under the reset register values.
    push_command(CMD_READ, 8'h00, 0, 0);
    put_byte(CH_PR_HI);
    put_byte(CH_PR_LO);
    put_byte(CH_BS);
    put_byte(CH_BS);
    put_byte(CH_BS);
    put_byte(8'h00);
    put_byte(8'h1F);
    put_byte(8'h7F);
    put_byte(8'hFF);
    push_command(CMD_SET, 8'hFF, 0, SCR_COLS - 1);
    put_byte(8'h5A);
    put_byte(CH_BS);
    put_byte(CH_CR);
    push_command(CMD_SET, 8'h00, SCR_ROWS - 1, SCR_COLS - 1);
    put_byte(8'h41);
    push_command(CMD_SET, 8'h55, SCR_ROWS - 1, 5);
    put_byte(CH_NL);
    push_command(CMD_SET, 8'hAA, 63, 127);
    push_command(CMD_SET, 8'h00, SCR_ROWS, 0);
    push_command(CMD_SET, 8'h00, 0, SCR_COLS);
    push_command(CMD_READ, 8'hFF, 63, 127);
    push_command(CMD_READ, 8'h00, SCR_ROWS - 2, SCR_COLS - 1);
    push_command(CMD_CLEAR, 8'hFF, 63, 127);
    push_command(CMD_READ, 8'h00, SCR_ROWS - 1, SCR_COLS - 1);

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      write_reg(REG_TEXT_COLOR, phase_colour[p]);
      write_reg(REG_CURSOR_HIDE, {7'd0, phase_hide[p]});
      queue_random_phase(PHASE_ITEMS);
    end

    wait_idle();
    if (expected_rsp.size() != 0)
      report_mismatch("result items never delivered", expected_rsp.size(), 0);
    $display("Run covered %0d command items under %0d register settings.",
             results_checked, NUM_PHASES + 1);
    $display("Predicted %0d scrolls, %0d clears and %0d rejected commands.",
             scroll_count, clear_count, reject_count);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Overall time limit for the run, sized for every item sweeping the store.
  initial begin
    #400_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
